// File: hdl/hex_lattice_metropolis_move_core_assert.svh
// Assertion macros shared by the lattice move core.
// Each one expects clk and arst_n in the scope where it is used.
`ifndef HEX_LATTICE_METROPOLIS_MOVE_CORE_ASSERT_SVH
`define HEX_LATTICE_METROPOLIS_MOVE_CORE_ASSERT_SVH

// Same-cycle implication.
`define HLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hlm: same-cycle check failed");

// Next-cycle implication.
`define HLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hlm: next-cycle check failed");

`endif

// File: hdl/hlm_pkg.sv
`default_nettype none
package hlm_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

	localparam int SIZE_W     = 7;
	localparam int ORIENT_W   = 3;
	localparam int MARGIN_W   = 16;
	localparam int ENERGY_W   = 17;
	localparam int ROM_W      = 14;
	localparam int STEP_W     = 3;
	localparam int NUM_DIRS   = 6;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// configuration register indexes
	localparam logic CFG_LATTICE_WIDTH  = 1'b0;
	localparam logic CFG_LATTICE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CENTER,
		ST_NBR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                clr;
		logic                en;
		logic [ORIENT_W-1:0] dir;
		logic [ORIENT_W-1:0] a_old;
		logic [ORIENT_W-1:0] a_new;
	} acc_ctrl_t;

	typedef struct packed {
		logic                we;
		logic                re;
		logic [ADDR_W-1:0]   addr;
		logic [ORIENT_W-1:0] wdata;
	} ram_req_t;

	// Pair energies, 12 fraction bits, [site][neighbour] after rotation by direction.
	localparam logic signed [ROM_W-1:0] PAIR_ROM [NUM_DIRS][NUM_DIRS] = '{
		'{-14'sd74,   14'sd4141, -14'sd192,  14'sd4051, -14'sd309,  -14'sd4545},
		'{ 14'sd1064, -14'sd74,  -14'sd81,  -14'sd309,  -14'sd978,   14'sd271},
		'{ 14'sd271, -14'sd4545,  14'sd91,  -14'sd4545,  14'sd271,   14'sd5156},
		'{-14'sd978, -14'sd309,  -14'sd81,  -14'sd74,    14'sd1064,  14'sd271},
		'{-14'sd309,  14'sd4051, -14'sd192,  14'sd4141, -14'sd74,   -14'sd4545},
		'{-14'sd81,  -14'sd192,   14'sd616, -14'sd192,  -14'sd81,    14'sd91}
	};

	// (a - d) mod 6 for a, d in 0..5
	function automatic logic [ORIENT_W-1:0] orient_sub(input logic [ORIENT_W-1:0] a,
		input logic [ORIENT_W-1:0] d);
		if (a >= d)
			return ORIENT_W'(a - d);
		else
			return ORIENT_W'(a + ORIENT_W'(NUM_DIRS) - d);
	endfunction

endpackage
`default_nettype wire

// File: hdl/hlm_req_if.sv
`default_nettype none
interface hlm_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [hlm_pkg::COL_W-1:0]    site_x;
	logic [hlm_pkg::ROW_W-1:0]    site_y;
	logic                         turn_up;
	logic [hlm_pkg::ORIENT_W-1:0] write_orientation;
	logic [hlm_pkg::MARGIN_W-1:0] accept_margin;

	modport source (output valid, req_type, site_x, site_y, turn_up, write_orientation,
		accept_margin, input ready);
	modport sink (input valid, req_type, site_x, site_y, turn_up, write_orientation,
		accept_margin, output ready);
endinterface
`default_nettype wire

// File: hdl/hlm_rsp_if.sv
`default_nettype none
interface hlm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                accepted;
	logic [hlm_pkg::ORIENT_W-1:0]        site_orientation;
	logic signed [hlm_pkg::ENERGY_W-1:0] energy_delta;
	logic                                out_of_grid;

	modport source (output valid, accepted, site_orientation, energy_delta, out_of_grid,
		input ready);
	modport sink (input valid, accepted, site_orientation, energy_delta, out_of_grid,
		output ready);
endinterface
`default_nettype wire

// File: hdl/hex_lattice_metropolis_move_core.sv
`default_nettype none
// Metropolis orientation update over a hexagonal lattice of up to 64 x 64 sites, odd rows
// shifted right by half a site, each site holding a six-way orientation in one single-port
// 4096 x 3 RAM. A request writes a site, reads a site, or proposes a +1/-1 turn at a site
// and keeps it when the local energy change (signed, 12 fraction bits) is zero or less or
// below the margin sent with the request. A write or an out-of-grid request goes straight
// to the finish, a read makes one center read, and a move makes one center read, six
// neighbour reads through the single RAM port with each accumulate in the step after its
// read, then the decision and write-back. The block is ready again in the cycle after the
// result is loaded; one item is in flight at a time. A finished result sits in an output
// register, so the next request is taken while it waits. Stored sites have no reset
// value: write a site before reading it or moving next to it. Write lattice_width and
// lattice_height only while idle; values above 64 act as 64 and 0 puts every site
// outside the grid.
module hex_lattice_metropolis_move_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	hlm_req_if.sink                         req,
	hlm_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [hlm_pkg::SIZE_W-1:0] cfg_wdata
);

	logic [hlm_pkg::SIZE_W-1:0] width_q;
	logic [hlm_pkg::SIZE_W-1:0] height_q;
	logic [hlm_pkg::SIZE_W-1:0] size_w;
	logic [hlm_pkg::SIZE_W-1:0] size_h;

	hlm_pkg::acc_ctrl_t                  acc_ctl;
	hlm_pkg::ram_req_t                   ram_req;
	logic [hlm_pkg::ORIENT_W-1:0]        ram_rdata;
	logic signed [hlm_pkg::ENERGY_W-1:0] delta;

	// Lattice size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hlm_pkg::SIZE_RESET;
			height_q <= hlm_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hlm_pkg::CFG_LATTICE_WIDTH:  width_q  <= cfg_wdata;
				hlm_pkg::CFG_LATTICE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the size in use to the storage geometry; the row stride never changes.
	assign size_w = (width_q > hlm_pkg::SIZE_W'(hlm_pkg::MAX_WIDTH)) ?
		hlm_pkg::SIZE_W'(hlm_pkg::MAX_WIDTH) : width_q;
	assign size_h = (height_q > hlm_pkg::SIZE_W'(hlm_pkg::MAX_HEIGHT)) ?
		hlm_pkg::SIZE_W'(hlm_pkg::MAX_HEIGHT) : height_q;

	// Sequencer: request decode, neighbour walk, decision and result register.
	hlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.size_w    (size_w),
		.size_h    (size_h),
		.acc_ctl   (acc_ctl),
		.delta     (delta),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Shared energy unit: two ROM lookups, one subtract and one add per neighbour.
	hlm_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.nbr    (ram_rdata),
		.delta  (delta)
	);

	// Site store, row-major with a fixed stride of MAX_WIDTH.
	hlm_ram #(
		.WIDTH (hlm_pkg::ORIENT_W),
		.DEPTH (hlm_pkg::DEPTH)
	) u_sites (
		.clk   (clk),
		.we    (ram_req.we),
		.re    (ram_req.re),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

// File: hdl/hlm_ram.sv
`default_nettype none
module hlm_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (re)
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hdl/hlm_acc.sv
`default_nettype none
module hlm_acc (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hlm_pkg::acc_ctrl_t                  ctl,
	input  wire logic [hlm_pkg::ORIENT_W-1:0]        nbr,
	output logic signed [hlm_pkg::ENERGY_W-1:0]      delta
);

	logic [hlm_pkg::ORIENT_W-1:0]        ia_old;
	logic [hlm_pkg::ORIENT_W-1:0]        ia_new;
	logic [hlm_pkg::ORIENT_W-1:0]        ib;
	logic signed [hlm_pkg::ROM_W-1:0]    e_old;
	logic signed [hlm_pkg::ROM_W-1:0]    e_new;
	logic signed [hlm_pkg::ENERGY_W-1:0] term;
	logic signed [hlm_pkg::ENERGY_W-1:0] acc_q;

	// rotate both orientations into the frame of the bond direction
	always_comb begin
		ia_old = hlm_pkg::orient_sub(ctl.a_old, ctl.dir);
		ia_new = hlm_pkg::orient_sub(ctl.a_new, ctl.dir);
		ib     = hlm_pkg::orient_sub(nbr, ctl.dir);
		e_old  = hlm_pkg::PAIR_ROM[ia_old][ib];
		e_new  = hlm_pkg::PAIR_ROM[ia_new][ib];
		term   = hlm_pkg::ENERGY_W'(e_new) - hlm_pkg::ENERGY_W'(e_old);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (ctl.clr)
			acc_q <= '0;
		else if (ctl.en)
			acc_q <= acc_q + term;
	end

	assign delta = acc_q;

endmodule
`default_nettype wire

// File: hdl/hlm_ctrl.sv
`default_nettype none
`include "hex_lattice_metropolis_move_core_assert.svh"
module hlm_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	hlm_req_if.sink                                  req,
	hlm_rsp_if.source                                rsp,
	input  wire logic [hlm_pkg::SIZE_W-1:0]          size_w,
	input  wire logic [hlm_pkg::SIZE_W-1:0]          size_h,
	output hlm_pkg::acc_ctrl_t                       acc_ctl,
	input  wire logic signed [hlm_pkg::ENERGY_W-1:0] delta,
	output hlm_pkg::ram_req_t                        ram_req,
	input  wire logic [hlm_pkg::ORIENT_W-1:0]        ram_rdata
);

	typedef struct packed {
		logic                      vld;
		logic [hlm_pkg::ADDR_W-1:0] addr;
	} nbr_t;

	hlm_pkg::state_t state_q, state_d;

	logic [1:0]                   req_q;
	logic [hlm_pkg::COL_W-1:0]    x_q;
	logic [hlm_pkg::ROW_W-1:0]    y_q;
	logic                         up_q;
	logic [hlm_pkg::ORIENT_W-1:0] wv_q;
	logic [hlm_pkg::MARGIN_W-1:0] margin_q;
	logic                         oog_q;
	logic [hlm_pkg::ORIENT_W-1:0] old_q;
	logic [hlm_pkg::STEP_W-1:0]   step_q;
	logic                         nb_vld_q;
	logic [hlm_pkg::ORIENT_W-1:0] nb_dir_q;

	logic                         rsp_valid_q;
	logic                         accepted_q;
	logic [hlm_pkg::ORIENT_W-1:0] orient_q;
	logic signed [hlm_pkg::ENERGY_W-1:0] delta_q;
	logic                         oog_out_q;

	logic                         take;
	logic                         in_oog;
	logic                         can_load;
	logic                         load;
	logic [hlm_pkg::ORIENT_W-1:0] new_orient;
	logic                         keep;
	logic                         res_acc;
	logic [hlm_pkg::ORIENT_W-1:0] res_orient;
	logic signed [hlm_pkg::ENERGY_W-1:0] res_delta;
	nbr_t                         nbr;

	// neighbour address and in-grid flag for the bond direction under step_q
	function automatic nbr_t nbr_of(input logic [hlm_pkg::COL_W-1:0] x,
		input logic [hlm_pkg::ROW_W-1:0] y, input logic [hlm_pkg::STEP_W-1:0] d,
		input logic [hlm_pkg::SIZE_W-1:0] w, input logic [hlm_pkg::SIZE_W-1:0] h);
		nbr_t                      r;
		logic                      odd;
		logic                      has_r;
		logic                      has_l;
		logic                      has_u;
		logic                      has_d;
		logic [hlm_pkg::COL_W-1:0] xr;
		logic [hlm_pkg::COL_W-1:0] xl;
		logic [hlm_pkg::ROW_W-1:0] yu;
		logic [hlm_pkg::ROW_W-1:0] yd;
		odd   = y[0];
		has_r = (hlm_pkg::SIZE_W'(x) + hlm_pkg::SIZE_W'(1)) < w;
		has_l = (x != '0);
		has_u = (y != '0);
		has_d = (hlm_pkg::SIZE_W'(y) + hlm_pkg::SIZE_W'(1)) < h;
		xr    = x + hlm_pkg::COL_W'(1);
		xl    = x - hlm_pkg::COL_W'(1);
		yu    = y - hlm_pkg::ROW_W'(1);
		yd    = y + hlm_pkg::ROW_W'(1);
		r     = '0;
		case (d)
			3'd0: r = '{has_r, {y, xr}};
			3'd1: r = odd ? '{has_u && has_r, {yu, xr}} : '{has_u, {yu, x}};
			3'd2: r = odd ? '{has_u, {yu, x}} : '{has_u && has_l, {yu, xl}};
			3'd3: r = '{has_l, {y, xl}};
			3'd4: r = odd ? '{has_d, {yd, x}} : '{has_d && has_l, {yd, xl}};
			3'd5: r = odd ? '{has_d && has_r, {yd, xr}} : '{has_d, {yd, x}};
			default: r = '0;
		endcase
		return r;
	endfunction

	assign take   = req.valid && req.ready;
	assign in_oog = (hlm_pkg::SIZE_W'(req.site_x) >= size_w) ||
		(hlm_pkg::SIZE_W'(req.site_y) >= size_h);
	assign can_load = !rsp_valid_q || rsp.ready;
	assign nbr      = nbr_of(x_q, y_q, step_q, size_w, size_h);

	always_comb begin
		if (up_q)
			new_orient = (old_q == hlm_pkg::ORIENT_W'(hlm_pkg::NUM_DIRS - 1)) ? '0 :
				old_q + hlm_pkg::ORIENT_W'(1);
		else
			new_orient = (old_q == '0) ? hlm_pkg::ORIENT_W'(hlm_pkg::NUM_DIRS - 1) :
				old_q - hlm_pkg::ORIENT_W'(1);
	end

	// downhill, flat, or uphill by less than the margin
	assign keep = (delta <= 0) ||
		($signed({delta[hlm_pkg::ENERGY_W-1], delta}) <
		$signed({2'b00, margin_q}));

	always_comb begin
		res_acc    = 1'b0;
		res_orient = '0;
		res_delta  = '0;
		if (!oog_q) begin
			case (req_q)
				hlm_pkg::REQ_WRITE: begin
					res_acc    = 1'b1;
					res_orient = wv_q;
				end
				hlm_pkg::REQ_MOVE: begin
					res_acc    = keep;
					res_orient = keep ? new_orient : old_q;
					res_delta  = delta;
				end
				default: begin
					res_acc    = (req_q == hlm_pkg::REQ_READ);
					res_orient = ram_rdata;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hlm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		req.ready     = 1'b0;
		load          = 1'b0;
		ram_req       = '0;
		acc_ctl       = '0;
		acc_ctl.dir   = nb_dir_q;
		acc_ctl.a_old = old_q;
		acc_ctl.a_new = new_orient;
		unique case (state_q)
			hlm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (in_oog || req.req_type == hlm_pkg::REQ_WRITE)
						state_d = hlm_pkg::ST_FIN;
					else
						state_d = hlm_pkg::ST_CENTER;
				end
			end
			hlm_pkg::ST_CENTER: begin
				ram_req.re   = 1'b1;
				ram_req.addr = {y_q, x_q};
				acc_ctl.clr  = 1'b1;
				state_d      = (req_q == hlm_pkg::REQ_MOVE) ? hlm_pkg::ST_NBR : hlm_pkg::ST_FIN;
			end
			hlm_pkg::ST_NBR: begin
				ram_req.re   = (step_q < hlm_pkg::STEP_W'(hlm_pkg::NUM_DIRS));
				ram_req.addr = nbr.addr;
				acc_ctl.en   = nb_vld_q;
				if (step_q == hlm_pkg::STEP_W'(hlm_pkg::NUM_DIRS))
					state_d = hlm_pkg::ST_FIN;
			end
			hlm_pkg::ST_FIN: begin
				if (can_load) begin
					load          = 1'b1;
					ram_req.addr  = {y_q, x_q};
					ram_req.we    = !oog_q && (req_q == hlm_pkg::REQ_WRITE ||
						(req_q == hlm_pkg::REQ_MOVE && keep));
					ram_req.wdata = (req_q == hlm_pkg::REQ_WRITE) ? wv_q : new_orient;
					state_d       = hlm_pkg::ST_IDLE;
				end
			end
			default: state_d = hlm_pkg::ST_IDLE;
		endcase
	end

	// item fields, held for the whole request
	always_ff @(posedge clk) begin
		if (take) begin
			req_q    <= req.req_type;
			x_q      <= req.site_x;
			y_q      <= req.site_y;
			up_q     <= req.turn_up;
			wv_q     <= (req.write_orientation >= hlm_pkg::ORIENT_W'(hlm_pkg::NUM_DIRS)) ?
				req.write_orientation - hlm_pkg::ORIENT_W'(hlm_pkg::NUM_DIRS) :
				req.write_orientation;
			margin_q <= req.accept_margin;
		end
		if (state_q == hlm_pkg::ST_NBR && step_q == '0)
			old_q <= ram_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oog_q    <= 1'b0;
			step_q   <= '0;
			nb_vld_q <= 1'b0;
			nb_dir_q <= '0;
		end else begin
			if (take)
				oog_q <= in_oog;
			if (state_q == hlm_pkg::ST_CENTER) begin
				step_q   <= '0;
				nb_vld_q <= 1'b0;
			end else if (state_q == hlm_pkg::ST_NBR) begin
				step_q   <= step_q + hlm_pkg::STEP_W'(1);
				nb_vld_q <= nbr.vld && (step_q < hlm_pkg::STEP_W'(hlm_pkg::NUM_DIRS));
				nb_dir_q <= step_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			accepted_q <= res_acc;
			orient_q   <= res_orient;
			delta_q    <= res_delta;
			oog_out_q  <= oog_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.accepted         = accepted_q;
	assign rsp.site_orientation = orient_q;
	assign rsp.energy_delta     = delta_q;
	assign rsp.out_of_grid      = oog_out_q;

	`HLM_ASSERT_IMP(a_write_only_at_finish, ram_req.we, state_q == hlm_pkg::ST_FIN)
	`HLM_ASSERT_IMP(a_no_result_overrun, load, !rsp_valid_q || rsp.ready)
	`HLM_ASSERT_IMP(a_acc_after_center, acc_ctl.en, state_q == hlm_pkg::ST_NBR && step_q != '0)
	`HLM_ASSERT_NXT(a_center_next, state_q == hlm_pkg::ST_CENTER,
		state_q == hlm_pkg::ST_NBR || state_q == hlm_pkg::ST_FIN)
	`HLM_ASSERT_IMP(a_oog_result_inert, rsp_valid_q && oog_out_q,
		!accepted_q && delta_q == '0 && orient_q == '0)

endmodule
`default_nettype wire

// File: tb/hex_lattice_metropolis_move_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module hex_lattice_metropolis_move_core_test;

	import hlm_pkg::*;

	// Read with the acknowledge bit left low; the package has no name for it.
	localparam logic [1:0] REQ_READ_QUIET = 2'd3;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either channel and no register write
	localparam int SETTLE_CYCLES  = 12;    // longest item (a move) plus margin
	localparam int STALL_CYCLES   = 300;   // receiver hold-off, long enough to back up the input
	localparam int WINDOW         = 8;     // side of the patch of sites a phase works on
	localparam int NUM_PHASES     = 12;

	// Neighbour directions around a site; odd rows sit half a site to the right.
	typedef enum int {
		DIR_RIGHT,
		DIR_UP_RIGHT,
		DIR_UP_LEFT,
		DIR_LEFT,
		DIR_DOWN_LEFT,
		DIR_DOWN_RIGHT
	} hex_dir_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [COL_W-1:0]    site_x;
		logic [ROW_W-1:0]    site_y;
		logic                turn_up;
		logic [ORIENT_W-1:0] write_orientation;
		logic [MARGIN_W-1:0] accept_margin;
	} site_request_t;

	typedef struct packed {
		logic                       accepted;
		logic [ORIENT_W-1:0]        site_orientation;
		logic signed [ENERGY_W-1:0] energy_delta;
		logic                       out_of_grid;
	} site_result_t;

	// One line of the directed table: either a resize or a request.
	typedef struct {
		bit            is_resize;
		int            width_reg;
		int            height_reg;
		site_request_t request;
		bit            typed;
		site_result_t  typed_result;
	} directed_row_t;

	// Pair energies in fixed point with 12 fraction bits, [site][neighbour] after rotation by direction.
	int pair_energy [6][6] = '{
		'{  -74,  4141,  -192,  4051,  -309, -4545},
		'{ 1064,   -74,   -81,  -309,  -978,   271},
		'{  271, -4545,    91, -4545,   271,  5156},
		'{ -978,  -309,   -81,   -74,  1064,   271},
		'{ -309,  4051,  -192,  4141,   -74, -4545},
		'{  -81,  -192,   616,  -192,   -81,    91}
	};

	// Lattice sizes per random phase, as written to the registers (values over 64 saturate).
	int phase_width  [NUM_PHASES] = '{64, 5, 1, 127, 8, 64, 1, 0, 9, 13, 2, 65};
	int phase_height [NUM_PHASES] = '{64, 4, 1, 100, 8, 1, 64, 9, 0, 7, 2, 3};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = 1'b0;
	logic [SIZE_W-1:0]   cfg_wdata = '0;

	hlm_req_if req_ch ();
	hlm_rsp_if rsp_ch ();

	// Tag that travels with each offered request: use the typed-in result instead of the
	// predicted one.
	bit           typed_tag = 1'b0;
	site_result_t typed_want = '0;

	// Predictor state: its own copy of the orientation store and the size registers.
	logic [ORIENT_W-1:0] lattice_orient [DEPTH];
	int                  lattice_width_reg;
	int                  lattice_height_reg;
	site_result_t        pending_results [$];

	// Directed table, filled at the start of the stimulus.
	directed_row_t directed_rows [$];

	// Stimulus bookkeeping: sizes in use and which sites have been written so far.
	bit site_known [DEPTH];
	int gen_width  = MAX_WIDTH;
	int gen_height = MAX_HEIGHT;

	int sent_count  = 0;
	int done_count  = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	bit idle_on       = 1'b1;
	bit stall_request = 1'b0;

	hex_lattice_metropolis_move_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Append one expectation behind the ones still outstanding.
	function automatic void expect_result(input site_result_t res);
		pending_results.insert(pending_results.size(), res);
	endfunction

	// Append one line to the directed table.
	function automatic void add_row(input directed_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// Address of the neighbour of (x, y) in direction dir, or -1 when it falls off the
	// lattice. Off-lattice candidates are caught by the bounds test at the end, which
	// covers every edge case of the offset rows.
	function automatic int neighbour_addr(input int x, input int y, input int dir,
		input int w, input int h);
		bit odd;
		int nx;
		int ny;
		odd = (y % 2) == 1;
		case (dir)
			DIR_RIGHT: begin
				nx = x + 1;
				ny = y;
			end
			DIR_UP_RIGHT: begin
				nx = odd ? x + 1 : x;
				ny = y - 1;
			end
			DIR_UP_LEFT: begin
				nx = odd ? x : x - 1;
				ny = y - 1;
			end
			DIR_LEFT: begin
				nx = x - 1;
				ny = y;
			end
			DIR_DOWN_LEFT: begin
				nx = odd ? x : x - 1;
				ny = y + 1;
			end
			default: begin
				nx = odd ? x + 1 : x;
				ny = y + 1;
			end
		endcase
		if (nx < 0 || ny < 0 || nx >= w || ny >= h)
			return -1;
		return ny * MAX_WIDTH + nx;
	endfunction

	// Local energy of (x, y) if it held orientation a, summed over in-lattice neighbours.
	function automatic int local_energy(input int x, input int y, input int a,
		input int w, input int h);
		int e;
		int nb;
		e = 0;
		for (int dir = DIR_RIGHT; dir <= DIR_DOWN_RIGHT; dir++) begin
			nb = neighbour_addr(x, y, dir, w, h);
			if (nb >= 0)
				e += pair_energy[(a + 6 - dir) % 6][(int'(lattice_orient[nb]) + 6 - dir) % 6];
		end
		return e;
	endfunction

	// Apply one request to the predictor's lattice and return the result it should give.
	function automatic site_result_t predict_site_update(input site_request_t r);
		site_result_t res;
		int w;
		int h;
		int x;
		int y;
		int addr;
		int old_o;
		int new_o;
		int delta;
		int margin;
		res = '0;
		w = lattice_width_reg > MAX_WIDTH ? MAX_WIDTH : lattice_width_reg;
		h = lattice_height_reg > MAX_HEIGHT ? MAX_HEIGHT : lattice_height_reg;
		x = r.site_x;
		y = r.site_y;
		margin = r.accept_margin;
		delta = 0;
		if (x >= w || y >= h) begin
			res.out_of_grid = 1'b1;
			return res;
		end
		addr = y * MAX_WIDTH + x;
		case (r.req_type)
			REQ_WRITE: begin
				// 6 and 7 wrap to 0 and 1
				new_o = r.write_orientation >= 6 ? r.write_orientation - 6 : r.write_orientation;
				lattice_orient[addr] = ORIENT_W'(new_o);
				res.site_orientation = ORIENT_W'(new_o);
				res.accepted = 1'b1;
			end
			REQ_MOVE: begin
				old_o = lattice_orient[addr] % 6;
				new_o = r.turn_up ? (old_o + 1) % 6 : (old_o + 5) % 6;
				delta = local_energy(x, y, new_o, w, h) - local_energy(x, y, old_o, w, h);
				if (delta <= 0 || delta < margin) begin
					lattice_orient[addr] = ORIENT_W'(new_o);
					res.site_orientation = ORIENT_W'(new_o);
					res.accepted = 1'b1;
				end else begin
					res.site_orientation = ORIENT_W'(old_o);
				end
			end
			default: begin
				res.site_orientation = lattice_orient[addr];
				res.accepted = r.req_type == REQ_READ;
			end
		endcase
		if (delta > 65535)
			delta = 65535;
		if (delta < -65536)
			delta = -65536;
		res.energy_delta = ENERGY_W'(delta);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 100)
			$display("result %0d: %s is %0d, want %0d", done_count, what, got, want);
	endtask

	// Track the register writes, check each result transfer against the oldest
	// expectation, and queue an expectation for each request transfer.
	always @(posedge clk or negedge arst_n) begin : scoreboard
		site_request_t r;
		site_result_t want;
		if (!arst_n) begin
			lattice_width_reg = 64;
			lattice_height_reg = 64;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LATTICE_WIDTH)
					lattice_width_reg = cfg_wdata;
				else
					lattice_height_reg = cfg_wdata;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				done_count++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.accepted !== want.accepted)
						report_mismatch("accepted", rsp_ch.accepted, want.accepted);
					if (rsp_ch.site_orientation !== want.site_orientation)
						report_mismatch("site_orientation", rsp_ch.site_orientation,
							want.site_orientation);
					if (rsp_ch.energy_delta !== want.energy_delta)
						report_mismatch("energy_delta", $signed(rsp_ch.energy_delta),
							$signed(want.energy_delta));
					if (rsp_ch.out_of_grid !== want.out_of_grid)
						report_mismatch("out_of_grid", rsp_ch.out_of_grid, want.out_of_grid);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				r.req_type = req_ch.req_type;
				r.site_x = req_ch.site_x;
				r.site_y = req_ch.site_y;
				r.turn_up = req_ch.turn_up;
				r.write_orientation = req_ch.write_orientation;
				r.accept_margin = req_ch.accept_margin;
				// always advance the predicted lattice, even for typed-in rows
				want = predict_site_update(r);
				expect_result(typed_tag ? typed_want : want);
			end
		end
	end

	// Watchdog: end the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("hex_lattice_metropolis_move_core_test NOT OK");
				$finish;
			end
		end
	end

	// Result side: take results at random, except when idling is off, and hold off for a
	// long stretch when asked so that the block backs up and stalls its input.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_request) begin
				stall_request = 1'b0;
				hold_left = STALL_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 29);
			end
		end
	end

	// Offer one request, with random gaps ahead of it, and hold it until the transfer.
	// Valid stays high afterwards so back-to-back requests need no second assignment.
	task automatic send_request(input site_request_t it, input bit typed,
		input site_result_t want);
		while (idle_on && $urandom_range(99) < 29) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.site_x <= it.site_x;
		req_ch.site_y <= it.site_y;
		req_ch.turn_up <= it.turn_up;
		req_ch.write_orientation <= it.write_orientation;
		req_ch.accept_margin <= it.accept_margin;
		typed_tag <= typed;
		typed_want <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_count++;
		if (it.req_type == REQ_WRITE && it.site_x < gen_width && it.site_y < gen_height)
			site_known[it.site_y * MAX_WIDTH + it.site_x] = 1'b1;
	endtask

	// Drop valid and wait until every outstanding result has come back, then let the
	// longest item finish.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (done_count != sent_count)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Resize the lattice while the block is idle: both registers, one per cycle.
	task automatic set_lattice(input int width_reg, input int height_reg);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LATTICE_WIDTH;
		cfg_wdata <= SIZE_W'(width_reg);
		@(posedge clk);
		cfg_index <= CFG_LATTICE_HEIGHT;
		cfg_wdata <= SIZE_W'(height_reg);
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_width = width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg;
		gen_height = height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg;
	endtask

	// First site that a request at (x, y) would read but that was never written, or -1.
	function automatic int first_unknown(input int x, input int y, input bit with_nbrs);
		int nb;
		if (!site_known[y * MAX_WIDTH + x])
			return y * MAX_WIDTH + x;
		if (with_nbrs) begin
			for (int dir = DIR_RIGHT; dir <= DIR_DOWN_RIGHT; dir++) begin
				nb = neighbour_addr(x, y, dir, gen_width, gen_height);
				if (nb >= 0 && !site_known[nb])
					return nb;
			end
		end
		return -1;
	endfunction

	function automatic site_request_t random_request();
		site_request_t it;
		it.req_type = 2'($urandom_range(3));
		it.site_x = COL_W'($urandom_range(63));
		it.site_y = ROW_W'($urandom_range(63));
		it.turn_up = 1'($urandom_range(1));
		it.write_orientation = ORIENT_W'($urandom_range(7));
		it.accept_margin = MARGIN_W'($urandom_range(65535));
		return it;
	endfunction

	function automatic site_request_t request_at(input logic [1:0] kind, input int x,
		input int y, input bit up, input int wv, input int margin);
		site_request_t it;
		it.req_type = kind;
		it.site_x = COL_W'(x);
		it.site_y = ROW_W'(y);
		it.turn_up = up;
		it.write_orientation = ORIENT_W'(wv);
		it.accept_margin = MARGIN_W'(margin);
		return it;
	endfunction

	function automatic site_result_t make_result(input bit acc, input int orient, input bit oog);
		site_result_t res;
		res = '0;
		res.accepted = acc;
		res.site_orientation = ORIENT_W'(orient);
		res.out_of_grid = oog;
		return res;
	endfunction

	// One random phase: resize, fill a patch of sites, then a mix weighted toward moves.
	task automatic random_phase(input int width_reg, input int height_reg, input int n_items,
		input bit with_stall);
		site_request_t it;
		site_result_t none;
		int x0;
		int y0;
		int pw;
		int ph;
		int x;
		int y;
		int u;
		int pick;
		none = '0;
		set_lattice(width_reg, height_reg);
		if (gen_width == 0 || gen_height == 0) begin
			// nothing is on the lattice: every request must bounce
			repeat (n_items) send_request(random_request(), 1'b0, none);
			return;
		end
		pw = gen_width < WINDOW ? gen_width : WINDOW;
		ph = gen_height < WINDOW ? gen_height : WINDOW;
		// put the patch on the far corner half the time, and always in a stall phase, so the bottom and right edges get moves
		x0 = (with_stall || $urandom_range(1)) ? gen_width - pw : $urandom_range(gen_width - pw);
		y0 = (with_stall || $urandom_range(1)) ? gen_height - ph :
			$urandom_range(gen_height - ph);
		for (int yy = y0; yy < y0 + ph; yy++)
			for (int xx = x0; xx < x0 + pw; xx++)
				if (!site_known[yy * MAX_WIDTH + xx]) begin
					it = random_request();
					it.req_type = REQ_WRITE;
					it.site_x = COL_W'(xx);
					it.site_y = ROW_W'(yy);
					send_request(it, 1'b0, none);
				end
		if (with_stall)
			stall_request = 1'b1;
		repeat (n_items) begin
			it = random_request();
			pick = $urandom_range(99);
			if (pick < 10 && (gen_width < MAX_WIDTH || gen_height < MAX_HEIGHT)) begin
				// off the lattice, any request type
				if (gen_width < MAX_WIDTH && (gen_height == MAX_HEIGHT || $urandom_range(1)))
					it.site_x = COL_W'($urandom_range(63, gen_width));
				else
					it.site_y = ROW_W'($urandom_range(63, gen_height));
			end else begin
				x = x0 + $urandom_range(pw - 1);
				y = y0 + $urandom_range(ph - 1);
				it.site_x = COL_W'(x);
				it.site_y = ROW_W'(y);
				if (pick < 65)
					it.req_type = REQ_MOVE;
				else if (pick < 77)
					it.req_type = REQ_WRITE;
				else if (pick < 92)
					it.req_type = REQ_READ;
				else
					it.req_type = REQ_READ_QUIET;
				if (it.req_type == REQ_MOVE) begin
					// mostly strict or modest margins, some anything goes
					u = $urandom_range(9);
					if (u < 3)
						it.accept_margin = '0;
					else if (u < 6)
						it.accept_margin = MARGIN_W'($urandom_range(4095));
				end
				if (it.req_type != REQ_WRITE) begin
					// never read an unwritten site: write the missing one first
					u = first_unknown(x, y, it.req_type == REQ_MOVE);
					if (u >= 0) begin
						it.req_type = REQ_WRITE;
						it.site_x = COL_W'(u % MAX_WIDTH);
						it.site_y = ROW_W'(u / MAX_WIDTH);
					end
				end
			end
			send_request(it, 1'b0, none);
		end
	endtask

	initial begin : stimulus
		directed_row_t row;
		site_result_t off_grid;
		site_result_t predicted;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_WRITE;
		req_ch.site_x = '0;
		req_ch.site_y = '0;
		req_ch.turn_up = 1'b0;
		req_ch.write_orientation = '0;
		req_ch.accept_margin = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		off_grid = make_result(1'b0, 0, 1'b1);
		predicted = '0;

		// Directed table. Rows at reset size run on the full 64 x 64 lattice, so the
		// corner at (63, 63) doubles as a check of the register reset value.
		row = '{default: '0};
		row.typed = 1'b1;
		row.request = request_at(REQ_WRITE, 0, 0, 0, 5, 0);
		row.typed_result = make_result(1'b1, 5, 1'b0);
		add_row(row);
		// orientations 7 and 6 wrap to 1 and 0
		row.request = request_at(REQ_WRITE, 63, 63, 1, 7, 65535);
		row.typed_result = make_result(1'b1, 1, 1'b0);
		add_row(row);
		row.request = request_at(REQ_WRITE, 1, 0, 0, 6, 0);
		row.typed_result = make_result(1'b1, 0, 1'b0);
		add_row(row);
		row.request = request_at(REQ_WRITE, 0, 1, 0, 2, 0);
		row.typed_result = make_result(1'b1, 2, 1'b0);
		add_row(row);
		row.request = request_at(REQ_WRITE, 62, 63, 0, 3, 0);
		row.typed_result = make_result(1'b1, 3, 1'b0);
		add_row(row);
		row.request = request_at(REQ_WRITE, 63, 62, 0, 4, 0);
		row.typed_result = make_result(1'b1, 4, 1'b0);
		add_row(row);
		row.request = request_at(REQ_READ, 63, 63, 0, 0, 0);
		row.typed_result = make_result(1'b1, 1, 1'b0);
		add_row(row);
		// request type three reads without acknowledging
		row.request = request_at(REQ_READ_QUIET, 0, 0, 1, 7, 65535);
		row.typed_result = make_result(1'b0, 5, 1'b0);
		add_row(row);

		// moves on the corners, strict and wide margins
		row.typed = 1'b0;
		row.typed_result = predicted;
		row.request = request_at(REQ_MOVE, 0, 0, 1, 0, 0);
		add_row(row);
		row.request = request_at(REQ_MOVE, 0, 0, 0, 0, 65535);
		add_row(row);
		row.request = request_at(REQ_MOVE, 63, 63, 1, 0, 0);
		add_row(row);
		row.request = request_at(REQ_MOVE, 63, 63, 0, 0, 4096);
		add_row(row);

		// shrink to 3 x 2: sites past either edge bounce for every request type
		row = '{default: '0};
		row.is_resize = 1'b1;
		row.width_reg = 3;
		row.height_reg = 2;
		add_row(row);
		row.is_resize = 1'b0;
		row.typed = 1'b1;
		row.typed_result = off_grid;
		row.request = request_at(REQ_WRITE, 3, 0, 0, 4, 0);
		add_row(row);
		row.request = request_at(REQ_MOVE, 2, 2, 1, 0, 65535);
		add_row(row);
		row.request = request_at(REQ_READ, 0, 63, 0, 0, 0);
		add_row(row);
		row.request = request_at(REQ_READ_QUIET, 63, 0, 0, 0, 0);
		add_row(row);
		// stored values keep their place across a resize
		row.request = request_at(REQ_READ, 0, 1, 0, 0, 0);
		row.typed_result = make_result(1'b1, 2, 1'b0);
		add_row(row);

		// zero width: everything is off the lattice
		row = '{default: '0};
		row.is_resize = 1'b1;
		row.width_reg = 0;
		row.height_reg = 2;
		add_row(row);
		row.is_resize = 1'b0;
		row.typed = 1'b1;
		row.typed_result = off_grid;
		row.request = request_at(REQ_WRITE, 0, 0, 0, 1, 0);
		add_row(row);

		// sizes above the maximum saturate to 64
		row = '{default: '0};
		row.is_resize = 1'b1;
		row.width_reg = 127;
		row.height_reg = 100;
		add_row(row);
		row.is_resize = 1'b0;
		row.typed = 1'b1;
		row.request = request_at(REQ_WRITE, 63, 63, 0, 0, 0);
		row.typed_result = make_result(1'b1, 0, 1'b0);
		add_row(row);
		row.request = request_at(REQ_READ, 63, 63, 0, 0, 0);
		add_row(row);

		// a single site has no neighbours, so any move is free
		row = '{default: '0};
		row.is_resize = 1'b1;
		row.width_reg = 1;
		row.height_reg = 1;
		add_row(row);
		row.is_resize = 1'b0;
		row.request = request_at(REQ_MOVE, 0, 0, 1, 0, 0);
		add_row(row);
		row.request = request_at(REQ_MOVE, 0, 0, 0, 0, 0);
		add_row(row);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_resize)
				set_lattice(directed_rows[i].width_reg, directed_rows[i].height_reg);
			else
				send_request(directed_rows[i].request, directed_rows[i].typed,
					directed_rows[i].typed_result);
		end

		// Random phases. The first one backs up the result side, the fourth runs with no
		// gaps on either side; every phase boundary drains the block before the resize.
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_on = p != 3;
			random_phase(phase_width[p], phase_height[p],
				(phase_width[p] == 0 || phase_height[p] == 0) ? 30 : 110, p == 0);
		end

		// Drain, let the last item settle, then give the verdict.
		idle_on = 1'b1;
		req_ch.valid <= 1'b0;
		while (done_count != sent_count)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		if (error_count == 0)
			$display("hex_lattice_metropolis_move_core_test OK");
		else
			$display("hex_lattice_metropolis_move_core_test NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
